@@ rtl/pcni_pkg.sv @@
// ============================================================================
// pcni_pkg
// Shared widths, register map and stage types of the periodic neighbour
// index block.
// ============================================================================
package pcni_pkg;

    localparam int MAX_CELLS_PER_AXIS = 64;
    localparam int NEIGHBOUR_SLOTS    = 26;
    localparam int RING_SLOTS         = 8;
    localparam int SLOT_UP_Z          = 24;
    localparam int SLOT_DN_Z          = 25;

    localparam int IDX_W   = 18;
    localparam int SLOT_W  = 5;
    localparam int AXIS_W  = 7;
    localparam int COORD_W = $clog2(MAX_CELLS_PER_AXIS);
    localparam int PLANE_W = 2 * COORD_W + 1;
    localparam int TOTAL_W = 3 * COORD_W + 1;

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    localparam logic [AXIS_W-1:0] AXIS_RESET = AXIS_W'(8);

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_CELLS_X = 2'd0;
    localparam logic [1:0] REG_CELLS_Y = 2'd1;
    localparam logic [1:0] REG_CELLS_Z = 2'd2;

    // stage 0 .. DIV_STAGES-1 sit in the divider, the rest in the back end
    localparam int DIV_STAGES  = 7;
    localparam int POST_STAGES = 3;
    localparam int NUM_STAGES  = DIV_STAGES + POST_STAGES;

    // grid geometry, axis counts already clamped
    typedef struct packed {
        logic [AXIS_W-1:0]  nx;
        logic [AXIS_W-1:0]  ny;
        logic [AXIS_W-1:0]  nz;
        logic [PLANE_W-1:0] plane;
        logic [TOTAL_W-1:0] total;
    } t_grid;

    // decomposed central cell leaving the divider
    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SLOT_W-1:0]  slot;
        logic               bad;
    } t_coord;

endpackage

@@ rtl/pcni_intf.sv @@
// ============================================================================
// pcni_intf
// Request and response channels of the periodic neighbour index block.
// ============================================================================
interface pcni_req_if;
    logic                           valid;
    logic                           ready;
    logic [pcni_pkg::IDX_W-1:0]     cell_index;
    logic [pcni_pkg::SLOT_W-1:0]    neighbour_slot;

    modport source (output valid, output cell_index, output neighbour_slot, input ready);
    modport sink   (input valid, input cell_index, input neighbour_slot, output ready);
endinterface

interface pcni_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pcni_pkg::IDX_W-1:0]     neighbour_index;
    logic                           bad_request;

    modport source (output valid, output neighbour_index, output bad_request, input ready);
    modport sink   (input valid, input neighbour_index, input bad_request, output ready);
endinterface

@@ rtl/pcni_cfg.sv @@
// ============================================================================
// pcni_cfg
// APB register file for the grid size, with clamped axis counts and
// registered plane and total cell counts.
// ============================================================================
module pcni_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcni_pkg::APB_AW-1:0]   paddr,
    input  logic [pcni_pkg::APB_DW-1:0]   pwdata,
    output logic [pcni_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output pcni_pkg::t_grid               o_grid
);

    logic [pcni_pkg::AXIS_W-1:0]  r_cells_x, r_cells_y, r_cells_z;
    logic [pcni_pkg::AXIS_W-1:0]  nx, ny, nz;
    logic [pcni_pkg::PLANE_W-1:0] r_plane, n_plane;
    logic [pcni_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [1:0]                   reg_sel;
    logic                         wr_en;

    localparam logic [pcni_pkg::AXIS_W-1:0] AXIS_MAX =
        pcni_pkg::AXIS_W'(pcni_pkg::MAX_CELLS_PER_AXIS);

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        nx = (r_cells_x > AXIS_MAX) ? AXIS_MAX : r_cells_x;
        ny = (r_cells_y > AXIS_MAX) ? AXIS_MAX : r_cells_y;
        nz = (r_cells_z > AXIS_MAX) ? AXIS_MAX : r_cells_z;
        n_plane = pcni_pkg::PLANE_W'(nx) * pcni_pkg::PLANE_W'(ny);
        // plane is registered from the clamped axis counts, total from the registered plane
        n_total = pcni_pkg::TOTAL_W'(r_plane) * pcni_pkg::TOTAL_W'(nz);
    end

    always_comb begin
        unique case (reg_sel)
            pcni_pkg::REG_CELLS_X: prdata = pcni_pkg::APB_DW'(r_cells_x);
            pcni_pkg::REG_CELLS_Y: prdata = pcni_pkg::APB_DW'(r_cells_y);
            pcni_pkg::REG_CELLS_Z: prdata = pcni_pkg::APB_DW'(r_cells_z);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= pcni_pkg::AXIS_RESET;
            r_cells_y <= pcni_pkg::AXIS_RESET;
            r_cells_z <= pcni_pkg::AXIS_RESET;
            r_plane   <= pcni_pkg::PLANE_W'(64);
            r_total   <= pcni_pkg::TOTAL_W'(512);
        end else begin
            r_plane <= n_plane;
            r_total <= n_total;
            if (wr_en) begin
                unique case (reg_sel)
                    pcni_pkg::REG_CELLS_X: r_cells_x <= pwdata[pcni_pkg::AXIS_W-1:0];
                    pcni_pkg::REG_CELLS_Y: r_cells_y <= pwdata[pcni_pkg::AXIS_W-1:0];
                    pcni_pkg::REG_CELLS_Z: r_cells_z <= pwdata[pcni_pkg::AXIS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_grid.nx    = nx;
    assign o_grid.ny    = ny;
    assign o_grid.nz    = nz;
    assign o_grid.plane = r_plane;
    assign o_grid.total = r_total;

endmodule

@@ rtl/pcni_div.sv @@
// ============================================================================
// pcni_div
// Input register and pipelined restoring divider: splits the linear cell
// index into plane, row and column, two quotient bits per stage.
// ============================================================================
module pcni_div (
    input  logic                                i_clk,
    input  logic [pcni_pkg::DIV_STAGES-1:0]     i_en,
    input  logic [pcni_pkg::IDX_W-1:0]          i_cell_index,
    input  logic [pcni_pkg::SLOT_W-1:0]         i_neighbour_slot,
    input  pcni_pkg::t_grid                     i_grid,
    output pcni_pkg::t_coord                    o_coord
);

    typedef struct packed {
        logic [pcni_pkg::TOTAL_W-1:0] rem;
        logic [1:0]                   q;
    } t_div2;

    // two restoring steps, quotient bits b and b-1
    function automatic t_div2 div2(input logic [pcni_pkg::TOTAL_W-1:0] rem,
                                   input logic [pcni_pkg::TOTAL_W-1:0] dvs,
                                   input int unsigned b);
        t_div2                        res;
        logic [pcni_pkg::TOTAL_W-1:0] t;
        res.rem = rem;
        res.q   = '0;
        t = dvs << b;
        if (res.rem >= t) begin
            res.rem  = res.rem - t;
            res.q[1] = 1'b1;
        end
        t = dvs << (b - 1);
        if (res.rem >= t) begin
            res.rem  = res.rem - t;
            res.q[0] = 1'b1;
        end
        return res;
    endfunction

    logic [pcni_pkg::IDX_W-1:0]   r_idx0, r_idx1;
    logic [pcni_pkg::SLOT_W-1:0]  r_slot [0:6];
    logic [pcni_pkg::IDX_W-1:0]   r_zrem [0:2];
    logic [pcni_pkg::IDX_W-1:0]   n_zrem [0:2];
    logic [pcni_pkg::COORD_W-1:0] r_zq   [0:2];
    logic [pcni_pkg::COORD_W-1:0] n_zq   [0:2];
    logic [pcni_pkg::PLANE_W-1:0] r_rrem [0:2];
    logic [pcni_pkg::PLANE_W-1:0] n_rrem [0:2];
    logic [pcni_pkg::COORD_W-1:0] r_rq   [0:2];
    logic [pcni_pkg::COORD_W-1:0] n_rq   [0:2];
    logic [pcni_pkg::COORD_W-1:0] r_z    [4:6];
    logic                         r_bad  [2:6];
    logic                         n_bad;
    logic [pcni_pkg::TOTAL_W-1:0] plane_w, nx_w;

    assign plane_w = pcni_pkg::TOTAL_W'(i_grid.plane);
    assign nx_w    = pcni_pkg::TOTAL_W'(i_grid.nx);

    always_comb begin
        t_div2 s;
        // plane number, divisor is the plane size
        s = div2(pcni_pkg::TOTAL_W'(r_idx0), plane_w, 5);
        n_zrem[0] = s.rem[pcni_pkg::IDX_W-1:0];
        n_zq[0]   = {s.q, 4'b0};
        s = div2(pcni_pkg::TOTAL_W'(r_zrem[0]), plane_w, 3);
        n_zrem[1] = s.rem[pcni_pkg::IDX_W-1:0];
        n_zq[1]   = {r_zq[0][5:4], s.q, 2'b0};
        s = div2(pcni_pkg::TOTAL_W'(r_zrem[1]), plane_w, 1);
        n_zrem[2] = s.rem[pcni_pkg::IDX_W-1:0];
        n_zq[2]   = {r_zq[1][5:2], s.q};
        // row number, remainder within the plane is below plane size
        s = div2(pcni_pkg::TOTAL_W'(r_zrem[2][pcni_pkg::PLANE_W-1:0]), nx_w, 5);
        n_rrem[0] = s.rem[pcni_pkg::PLANE_W-1:0];
        n_rq[0]   = {s.q, 4'b0};
        s = div2(pcni_pkg::TOTAL_W'(r_rrem[0]), nx_w, 3);
        n_rrem[1] = s.rem[pcni_pkg::PLANE_W-1:0];
        n_rq[1]   = {r_rq[0][5:4], s.q, 2'b0};
        s = div2(pcni_pkg::TOTAL_W'(r_rrem[1]), nx_w, 1);
        n_rrem[2] = s.rem[pcni_pkg::PLANE_W-1:0];
        n_rq[2]   = {r_rq[1][5:2], s.q};
        // a zero-sized grid has total zero, so every index fails here
        n_bad = ({1'b0, r_idx1} >= i_grid.total) ||
                (r_slot[1] >= pcni_pkg::SLOT_W'(pcni_pkg::NEIGHBOUR_SLOTS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_idx0    <= i_cell_index;
            r_slot[0] <= i_neighbour_slot;
        end
        if (i_en[1]) begin
            r_zrem[0] <= n_zrem[0];
            r_zq[0]   <= n_zq[0];
            r_idx1    <= r_idx0;
        end
        if (i_en[2]) begin
            r_zrem[1] <= n_zrem[1];
            r_zq[1]   <= n_zq[1];
            r_bad[2]  <= n_bad;
        end
        if (i_en[3]) begin
            r_zrem[2] <= n_zrem[2];
            r_zq[2]   <= n_zq[2];
            r_bad[3]  <= r_bad[2];
        end
        if (i_en[4]) begin
            r_rrem[0] <= n_rrem[0];
            r_rq[0]   <= n_rq[0];
            r_z[4]    <= r_zq[2];
            r_bad[4]  <= r_bad[3];
        end
        if (i_en[5]) begin
            r_rrem[1] <= n_rrem[1];
            r_rq[1]   <= n_rq[1];
            r_z[5]    <= r_z[4];
            r_bad[5]  <= r_bad[4];
        end
        if (i_en[6]) begin
            r_rrem[2] <= n_rrem[2];
            r_rq[2]   <= n_rq[2];
            r_z[6]    <= r_z[5];
            r_bad[6]  <= r_bad[5];
        end
        for (int k = 1; k < pcni_pkg::DIV_STAGES; k++) begin
            if (i_en[k]) begin
                r_slot[k] <= r_slot[k-1];
            end
        end
    end

    assign o_coord.z    = r_z[6];
    assign o_coord.row  = r_rq[2];
    assign o_coord.col  = r_rrem[2][pcni_pkg::COORD_W-1:0];
    assign o_coord.slot = r_slot[6];
    assign o_coord.bad  = r_bad[6];

endmodule

@@ rtl/pcni_post.sv @@
// ============================================================================
// pcni_post
// Slot decode with periodic wrap, partial products of the neighbour index
// and the final sum into the output register.
// ============================================================================
module pcni_post (
    input  logic                                i_clk,
    input  logic [pcni_pkg::POST_STAGES-1:0]    i_en,
    input  pcni_pkg::t_coord                    i_coord,
    input  pcni_pkg::t_grid                     i_grid,
    output logic [pcni_pkg::IDX_W-1:0]          o_neighbour_index,
    output logic                                o_bad_request
);

    typedef enum logic [1:0] {
        STEP_DN,
        STEP_HOLD,
        STEP_UP
    } t_step;

    function automatic logic [pcni_pkg::COORD_W-1:0] wrap(
        input logic [pcni_pkg::COORD_W-1:0] c,
        input t_step                        d,
        input logic [pcni_pkg::AXIS_W-1:0]  n
    );
        logic [pcni_pkg::AXIS_W-1:0]  up;
        logic [pcni_pkg::AXIS_W-1:0]  top_c;
        logic [pcni_pkg::COORD_W-1:0] res;
        up    = pcni_pkg::AXIS_W'(c) + 1'b1;
        top_c = n - 1'b1;
        case (d)
            STEP_UP: res = (up >= n) ? '0 : up[pcni_pkg::COORD_W-1:0];
            STEP_DN: res = (c == '0) ? top_c[pcni_pkg::COORD_W-1:0] : c - 1'b1;
            default: res = c;
        endcase
        return res;
    endfunction

    localparam logic [pcni_pkg::SLOT_W-1:0] RING_LAST =
        pcni_pkg::SLOT_W'(pcni_pkg::RING_SLOTS - 1);
    localparam logic [pcni_pkg::SLOT_W-1:0] RING_UP_FIRST =
        pcni_pkg::SLOT_W'(pcni_pkg::RING_SLOTS);
    localparam logic [pcni_pkg::SLOT_W-1:0] RING_UP_LAST =
        pcni_pkg::SLOT_W'(2 * pcni_pkg::RING_SLOTS - 1);
    localparam logic [pcni_pkg::SLOT_W-1:0] RING_DN_FIRST =
        pcni_pkg::SLOT_W'(2 * pcni_pkg::RING_SLOTS);
    localparam logic [pcni_pkg::SLOT_W-1:0] RING_DN_LAST =
        pcni_pkg::SLOT_W'(3 * pcni_pkg::RING_SLOTS - 1);
    localparam logic [pcni_pkg::SLOT_W-1:0] SLOT_UP =
        pcni_pkg::SLOT_W'(pcni_pkg::SLOT_UP_Z);

    t_step                        dr, dc, dz;
    logic [pcni_pkg::COORD_W-1:0] r_z1, r_row1, r_col1;
    logic [pcni_pkg::COORD_W-1:0] n_z1, n_row1, n_col1;
    logic                         r_bad1, r_bad2;
    logic [pcni_pkg::TOTAL_W-1:0] r_zp, n_zp;
    logic [pcni_pkg::PLANE_W-1:0] r_rn, n_rn;
    logic [pcni_pkg::COORD_W-1:0] r_col2;
    logic [pcni_pkg::TOTAL_W-1:0] n_sum;
    logic [pcni_pkg::IDX_W-1:0]   r_out, n_out;
    logic                         r_bad3;

    always_comb begin
        case (i_coord.slot) inside
            [5'd0 : RING_LAST]:          dz = STEP_HOLD;
            [RING_UP_FIRST : RING_UP_LAST]: dz = STEP_UP;
            [RING_DN_FIRST : RING_DN_LAST]: dz = STEP_DN;
            SLOT_UP:                     dz = STEP_UP;
            default:                     dz = STEP_DN;
        endcase
        if (i_coord.slot > RING_DN_LAST) begin
            // pure z neighbours keep row and column
            dr = STEP_HOLD;
            dc = STEP_HOLD;
        end else begin
            case (i_coord.slot[2:0]) inside
                3'd0, 3'd1, 3'd2: dr = STEP_UP;
                3'd3, 3'd4:       dr = STEP_HOLD;
                default:          dr = STEP_DN;
            endcase
            case (i_coord.slot[2:0]) inside
                3'd0, 3'd3, 3'd5: dc = STEP_DN;
                3'd1, 3'd6:       dc = STEP_HOLD;
                default:          dc = STEP_UP;
            endcase
        end
        n_row1 = wrap(i_coord.row, dr, i_grid.ny);
        n_col1 = wrap(i_coord.col, dc, i_grid.nx);
        n_z1   = wrap(i_coord.z,   dz, i_grid.nz);
        n_zp   = pcni_pkg::TOTAL_W'(r_z1) * pcni_pkg::TOTAL_W'(i_grid.plane);
        n_rn   = pcni_pkg::PLANE_W'(r_row1) * pcni_pkg::PLANE_W'(i_grid.nx);
        n_sum  = r_zp + pcni_pkg::TOTAL_W'(r_rn) + pcni_pkg::TOTAL_W'(r_col2);
        n_out  = r_bad2 ? '0 : n_sum[pcni_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_z1   <= n_z1;
            r_row1 <= n_row1;
            r_col1 <= n_col1;
            r_bad1 <= i_coord.bad;
        end
        if (i_en[1]) begin
            r_zp   <= n_zp;
            r_rn   <= n_rn;
            r_col2 <= r_col1;
            r_bad2 <= r_bad1;
        end
        if (i_en[2]) begin
            r_out  <= n_out;
            r_bad3 <= r_bad2;
        end
    end

    assign o_neighbour_index = r_out;
    assign o_bad_request     = r_bad3;

endmodule

@@ rtl/periodic_cell_neighbour_index_top.sv @@
// ============================================================================
// periodic_cell_neighbour_index_top
// Periodic 26-neighbour linear index of a 3-D cell grid, one request per
// cycle unless the response side stalls, grid size set over APB.
// ============================================================================
// One request word is accepted per cycle unless the response side stalls;
// a restoring divider splits the cell index into plane, row and column two
// quotient bits per stage (six stages after the input register), then one
// wrap stage, one stage of partial products and the output sum register.
// Each stage holds its word while the stage after it is full and stalled, so
// a stall at the response side backs up only as far as the bubbles allow.
// Plane and total follow a grid write through their registers. The user must
// change grid registers only while no request is in flight (not enforced).
module periodic_cell_neighbour_index_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pcni_req_if.sink                      i_req,
    pcni_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcni_pkg::APB_AW-1:0]   paddr,
    input  logic [pcni_pkg::APB_DW-1:0]   pwdata,
    output logic [pcni_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int NS = pcni_pkg::NUM_STAGES;

    pcni_pkg::t_grid  grid;
    pcni_pkg::t_coord coord;
    logic [NS-1:0]    r_vld;
    logic [NS-1:0]    en;
    logic             in_fire;

    // a stage may load when it or any stage after it is empty, or the sink takes
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            en[k] = o_rsp.ready || !(&(r_vld | NS'((1 << k) - 1)));
        end
    end

    assign i_req.ready = en[0];
    assign in_fire     = i_req.valid && en[0];
    assign o_rsp.valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= in_fire;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    pcni_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_grid  (grid)
    );

    pcni_div u_div (
        .i_clk            (i_clk),
        .i_en             (en[pcni_pkg::DIV_STAGES-1:0]),
        .i_cell_index     (i_req.cell_index),
        .i_neighbour_slot (i_req.neighbour_slot),
        .i_grid           (grid),
        .o_coord          (coord)
    );

    pcni_post u_post (
        .i_clk             (i_clk),
        .i_en              (en[NS-1:pcni_pkg::DIV_STAGES]),
        .i_coord           (coord),
        .i_grid            (grid),
        .o_neighbour_index (o_rsp.neighbour_index),
        .o_bad_request     (o_rsp.bad_request)
    );

`ifndef ASSERT_OFF
    // an empty or draining output slot never blocks the request side
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_rsp.valid || o_rsp.ready) |-> i_req.ready)
        else $error("request blocked while output slot free");

    // rejected requests carry index zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bad_request) |-> (o_rsp.neighbour_index == '0))
        else $error("bad request with nonzero index");

    // a good neighbour lies inside the grid
    a_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.bad_request) |->
            ({1'b0, o_rsp.neighbour_index} < grid.total))
        else $error("neighbour index outside grid");

    // an accepted word lands in the first stage
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_vld[0])
        else $error("accepted word lost at input stage");
`endif

endmodule

@@ dv/periodic_cell_neighbour_index_top_tb.sv @@
// ============================================================================
// periodic_cell_neighbour_index_top_tb
// Self-checking bench for the periodic 26-neighbour cell index block. Request
// words go in through the request channel and every accepted word is
// predicted from a local copy of the grid registers. Response words are
// compared field by field against the oldest pending prediction. The bench
// covers the reset grid, single-cell and empty grids, oversized axis counts,
// random grids with random idling on both channels, a long response
// hold-off and a final stretch with no idling.
// ============================================================================
module periodic_cell_neighbour_index_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY  = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_WORDS   = 140;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [pcni_pkg::IDX_W-1:0] index;
        logic                       bad;
    } t_nbr;

    // row and column steps of the in-plane ring
    localparam int RING_DROW [pcni_pkg::RING_SLOTS] = '{1, 1, 1, 0, 0, -1, -1, -1};
    localparam int RING_DCOL [pcni_pkg::RING_SLOTS] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [pcni_pkg::APB_AW-1:0]  paddr;
    logic [pcni_pkg::APB_DW-1:0]  pwdata;
    logic [pcni_pkg::APB_DW-1:0]  prdata;
    logic                         pready;

    pcni_req_if req_if ();
    pcni_rsp_if rsp_if ();

    periodic_cell_neighbour_index_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [pcni_pkg::AXIS_W-1:0] grid_x = pcni_pkg::AXIS_RESET;
    logic [pcni_pkg::AXIS_W-1:0] grid_y = pcni_pkg::AXIS_RESET;
    logic [pcni_pkg::AXIS_W-1:0] grid_z = pcni_pkg::AXIS_RESET;

    t_nbr        pending_nbrs [$];
    int unsigned mismatches      = 0;
    int unsigned idle_cycles     = 0;
    bit          req_gaps_on     = 1'b1;
    bit          rsp_stall_on    = 1'b1;
    int unsigned rsp_hold_cycles = 0;

    always #1 i_clk = ~i_clk;

    function automatic int unsigned axis_len(logic [pcni_pkg::AXIS_W-1:0] v);
        return (v > pcni_pkg::MAX_CELLS_PER_AXIS) ? pcni_pkg::MAX_CELLS_PER_AXIS : int'(v);
    endfunction

    function automatic int unsigned wrap(int unsigned c, int d, int unsigned n);
        if (d > 0) return (c + 1 >= n) ? 0 : c + 1;
        if (d < 0) return (c == 0) ? n - 1 : c - 1;
        return c;
    endfunction

    function automatic int unsigned grid_cells();
        return axis_len(grid_x) * axis_len(grid_y) * axis_len(grid_z);
    endfunction

    function automatic t_nbr neighbour_of(logic [pcni_pkg::IDX_W-1:0] centre,
                                          logic [pcni_pkg::SLOT_W-1:0] slot);
        int unsigned nx, ny, nz, plane, z, row, col;
        int          dr, dc, dz;
        t_nbr        r;
        nx = axis_len(grid_x);
        ny = axis_len(grid_y);
        nz = axis_len(grid_z);
        plane = nx * ny;
        r.index = '0;
        r.bad   = 1'b1;
        // an empty grid rejects everything
        if (plane * nz == 0 || centre >= plane * nz || slot >= pcni_pkg::NEIGHBOUR_SLOTS)
            return r;
        z   = centre / plane;
        row = (centre % plane) / nx;
        col = centre % nx;
        dr = 0;
        dc = 0;
        dz = 0;
        if (slot < pcni_pkg::SLOT_UP_Z) begin
            dr = RING_DROW[slot % pcni_pkg::RING_SLOTS];
            dc = RING_DCOL[slot % pcni_pkg::RING_SLOTS];
            if (slot >= 2 * pcni_pkg::RING_SLOTS)
                dz = -1;
            else if (slot >= pcni_pkg::RING_SLOTS)
                dz = 1;
        end else begin
            dz = (slot == pcni_pkg::SLOT_UP_Z) ? 1 : -1;
        end
        r.index = pcni_pkg::IDX_W'(wrap(z, dz, nz) * plane + wrap(row, dr, ny) * nx +
                                   wrap(col, dc, nx));
        r.bad   = 1'b0;
        return r;
    endfunction

    function automatic logic [pcni_pkg::AXIS_W-1:0] random_axis();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return pcni_pkg::AXIS_W'($urandom_range(pcni_pkg::MAX_CELLS_PER_AXIS + 1,
                                                             127));
            2:       return pcni_pkg::AXIS_W'(1);
            3:       return pcni_pkg::AXIS_W'(pcni_pkg::MAX_CELLS_PER_AXIS);
            default: return pcni_pkg::AXIS_W'($urandom_range(1, pcni_pkg::MAX_CELLS_PER_AXIS));
        endcase
    endfunction

    // prediction on request accept, comparison on response accept, watchdog
    always @(posedge i_clk) begin
        t_nbr want;
        if (i_rst_n && req_if.valid && req_if.ready)
            pending_nbrs.push_back(neighbour_of(req_if.cell_index, req_if.neighbour_slot));
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_nbrs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, actual index %0d bad %0b",
                         $time, rsp_if.neighbour_index, rsp_if.bad_request);
            end else begin
                want = pending_nbrs.pop_front();
                if (rsp_if.neighbour_index !== want.index) begin
                    mismatches++;
                    $display("%0t: neighbour_index mismatch: expected %0d, actual %0d",
                             $time, want.index, rsp_if.neighbour_index);
                end
                if (rsp_if.bad_request !== want.bad) begin
                    mismatches++;
                    $display("%0t: bad_request mismatch: expected %0b, actual %0b",
                             $time, want.bad, rsp_if.bad_request);
                end
            end
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("periodic_cell_neighbour_index_top regression: fail");
            $finish;
        end
    end

    // response side: random stall bursts, or one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_cycles != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge i_clk);
                rsp_hold_cycles = 0;
            end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [pcni_pkg::IDX_W-1:0] centre,
                             input logic [pcni_pkg::SLOT_W-1:0] slot);
        if (req_gaps_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.cell_index     <= centre;
        req_if.neighbour_slot <= slot;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        // let the checker log the word accepted at this edge first
        @(posedge i_clk);
        while (pending_nbrs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_idx,
                             input logic [pcni_pkg::AXIS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= pcni_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            pcni_pkg::REG_CELLS_X: grid_x = value;
            pcni_pkg::REG_CELLS_Y: grid_y = value;
            pcni_pkg::REG_CELLS_Z: grid_z = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [pcni_pkg::AXIS_W-1:0] nx,
                            input logic [pcni_pkg::AXIS_W-1:0] ny,
                            input logic [pcni_pkg::AXIS_W-1:0] nz);
        drain();
        write_reg(pcni_pkg::REG_CELLS_X, nx);
        write_reg(pcni_pkg::REG_CELLS_Y, ny);
        write_reg(pcni_pkg::REG_CELLS_Z, nz);
        // let the new geometry pass through the plane and total registers
        repeat (3) @(posedge i_clk);
    endtask

    task automatic test_reset_grid();
        send_word(0, 0);
        send_word(0, 7);
        send_word(0, 8);
        send_word(0, 15);
        send_word(0, 16);
        send_word(0, 23);
        send_word(0, pcni_pkg::SLOT_W'(pcni_pkg::SLOT_UP_Z));
        send_word(0, pcni_pkg::SLOT_W'(pcni_pkg::SLOT_DN_Z));
        send_word(511, 2);
        send_word(511, 12);
        send_word(511, pcni_pkg::SLOT_W'(pcni_pkg::SLOT_UP_Z));
        send_word(512, 0);
        send_word('1, 5);
        send_word(37, pcni_pkg::SLOT_W'(pcni_pkg::NEIGHBOUR_SLOTS));
        send_word(0, '1);
    endtask

    task automatic test_single_cell();
        set_grid(1, 1, 1);
        send_word(0, 0);
        send_word(0, 13);
        send_word(0, pcni_pkg::SLOT_W'(pcni_pkg::SLOT_DN_Z));
        send_word(1, 4);
    endtask

    task automatic test_empty_grid();
        set_grid(3, 5, 0);
        send_word(0, pcni_pkg::SLOT_W'(pcni_pkg::SLOT_UP_Z));
        set_grid(0, 4, 4);
        send_word(0, 0);
    endtask

    task automatic test_oversized_axes();
        set_grid(127, 127, 127);
        send_word('1, pcni_pkg::SLOT_W'(pcni_pkg::SLOT_UP_Z));
        send_word(0, pcni_pkg::SLOT_W'(pcni_pkg::SLOT_DN_Z));
        send_word('1, 2);
        send_word(4096, 16);
    endtask

    task automatic test_random_grids();
        int unsigned cells;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                set_grid(pcni_pkg::AXIS_W'(pcni_pkg::MAX_CELLS_PER_AXIS),
                         pcni_pkg::AXIS_W'(pcni_pkg::MAX_CELLS_PER_AXIS),
                         pcni_pkg::AXIS_W'(pcni_pkg::MAX_CELLS_PER_AXIS));
            else
                set_grid(random_axis(), random_axis(), random_axis());
            cells = grid_cells();
            for (int i = 0; i < PHASE_WORDS; i++) begin
                // mostly in-grid requests, the rest raw noise
                if (cells == 0 || $urandom_range(0, 9) == 0)
                    send_word(pcni_pkg::IDX_W'($urandom), pcni_pkg::SLOT_W'($urandom));
                else
                    send_word(pcni_pkg::IDX_W'($urandom_range(0, cells - 1)),
                              pcni_pkg::SLOT_W'($urandom_range(0,
                                  pcni_pkg::NEIGHBOUR_SLOTS - 1)));
            end
        end
    endtask

    task automatic test_response_hold();
        int unsigned cells;
        set_grid(16, 9, 5);
        cells = grid_cells();
        req_gaps_on     = 1'b0;
        rsp_stall_on    = 1'b0;
        rsp_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 60; i++)
            send_word(pcni_pkg::IDX_W'($urandom_range(0, cells - 1)),
                      pcni_pkg::SLOT_W'($urandom_range(0, pcni_pkg::NEIGHBOUR_SLOTS - 1)));
    endtask

    task automatic test_streaming();
        int unsigned cells;
        set_grid(pcni_pkg::AXIS_W'($urandom_range(2, pcni_pkg::MAX_CELLS_PER_AXIS)),
                 pcni_pkg::AXIS_W'($urandom_range(2, pcni_pkg::MAX_CELLS_PER_AXIS)),
                 pcni_pkg::AXIS_W'($urandom_range(2, pcni_pkg::MAX_CELLS_PER_AXIS)));
        cells = grid_cells();
        req_gaps_on  = 1'b0;
        rsp_stall_on = 1'b0;
        for (int i = 0; i < 200; i++)
            send_word(pcni_pkg::IDX_W'($urandom_range(0, cells - 1)),
                      pcni_pkg::SLOT_W'($urandom));
    endtask

    initial begin
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_if.valid          = 1'b0;
        req_if.cell_index     = '0;
        req_if.neighbour_slot = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_grid();
        test_single_cell();
        test_empty_grid();
        test_oversized_axes();
        req_gaps_on  = 1'b1;
        rsp_stall_on = 1'b1;
        test_random_grids();
        test_response_hold();
        test_streaming();

        drain();
        repeat (3 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatches == 0)
            $display("periodic_cell_neighbour_index_top regression: pass");
        else
            $display("periodic_cell_neighbour_index_top regression: fail");
        $finish;
    end

endmodule
